// ===== design/dmaq_pkg.sv =====
package dmaq_pkg;

    // default ring size
    localparam int unsigned QUEUE_DEPTH_DEF = 32;

    // request actions
    localparam logic ACT_SUBMIT   = 1'b0;
    localparam logic ACT_COMPLETE = 1'b1;

    // highest valid channel mode
    localparam logic [2:0] MODE_MAX = 3'd3;

    // result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_BAD_MODE = 2'd2;
    localparam logic [1:0] STATUS_SPURIOUS = 2'd3;

    // control encoding
    localparam logic [15:0] REV_NEW_MIN  = 16'd17;
    localparam logic [1:0]  MODE_SPECIAL = 2'd1;
    localparam logic [2:0]  CTRL_OLD     = 3'h4;
    localparam logic [2:0]  CTRL_NEW     = 3'h6;

    // one stored descriptor, 84 bits
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] addr;
        logic [31:0] count;
        logic        dir;
        logic        notify;
        logic [15:0] tag;
    } desc_t;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [2:0]  ctrl;
        logic [31:0] addr;
        logic [31:0] count;
        logic        dir;
        logic [15:0] tag;
        logic        last;
    } res_t;

    // control value from mode and chip revision
    function automatic logic [2:0] dma_ctrl(input logic [1:0] mode, input logic [15:0] rev);
        logic [2:0] code;
        code = {2'b00, (mode == MODE_SPECIAL)};
        return (rev < REV_NEW_MIN) ? (CTRL_OLD | code) : (CTRL_NEW | code);
    endfunction

    // status report, always the last result
    function automatic res_t status_res(input logic [1:0] st);
        res_t r;
        r        = '0;
        r.kind   = KIND_STATUS;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    // start command for a descriptor
    function automatic res_t start_res(input desc_t d, input logic [15:0] rev,
                                       input logic is_last);
        res_t r;
        r       = '0;
        r.kind  = KIND_START;
        r.ctrl  = dma_ctrl(d.mode, rev);
        r.addr  = d.addr;
        r.count = d.count;
        r.dir   = d.dir;
        r.last  = is_last;
        return r;
    endfunction

    // done report with the requester tag
    function automatic res_t done_res(input logic [15:0] t);
        res_t r;
        r      = '0;
        r.kind = KIND_DONE;
        r.tag  = t;
        r.last = 1'b1;
        return r;
    endfunction

endpackage

// ===== design/dma_descriptor_ring_queue_top.sv =====
// DMA descriptor ring queue. A request is taken when start is high and busy is
// low; action 0 submits a transfer descriptor, action 1 reports completion of
// the running transfer. Every result appears for exactly one cycle with
// result_strobe high and must be taken then: there is no back-pressure on the
// result side. A submit, or a completion on an empty ring, gives its first
// result in the cycle after the request; a completion on a non-empty ring first
// reads the head and following descriptors from the descriptor memory in the
// READ state before its first result. A request that gives a single status
// result leaves busy low; a submit into an empty ring (start command then
// status) holds busy high in the SECOND state, and a completion on a non-empty
// ring in the READ state, and in SECOND too when it gives both a start command
// and a done report; it may give no result at all. The ring holds QUEUE_DEPTH-1
// descriptors; the descriptor memory needs no clearing after reset.
module dma_descriptor_ring_queue_top #(
    parameter int unsigned QUEUE_DEPTH = dmaq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [2:0]  mode,
    input  logic [31:0] mem_address,
    input  logic [31:0] block_count,
    input  logic        direction,
    input  logic        notify,
    input  logic [15:0] tag,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // result channel
    output logic        result_strobe,
    output logic [1:0]  kind,
    output logic [1:0]  status,
    output logic [2:0]  dma_ctrl_value,
    output logic [31:0] start_address,
    output logic [31:0] start_count,
    output logic        start_direction,
    output logic [15:0] done_tag,
    output logic        last
);
    import dmaq_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_SECOND = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic             transfer_enable_reg, transfer_enable_next;
    logic [15:0]      chip_rev_reg;
    logic             strobe_reg, strobe_next;
    res_t             out_reg, out_next;
    res_t             pend_reg, pend_next;

    logic             accept;
    logic             ring_empty;
    logic             ring_full;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_inc;
    logic             mem_we;
    desc_t            new_desc;
    desc_t            head_desc;
    desc_t            next_desc;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign accept     = start && !busy;
    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);
    assign rd_ptr_inc = ptr_inc(rd_ptr_reg);
    assign ring_empty = (wr_ptr_reg == rd_ptr_reg);
    assign ring_full  = (wr_ptr_inc == rd_ptr_reg);

    // descriptor built from the request
    always_comb
    begin
        new_desc.mode   = mode[1:0];
        new_desc.addr   = mem_address;
        new_desc.count  = block_count;
        new_desc.dir    = direction;
        new_desc.notify = notify;
        new_desc.tag    = tag;
    end

    // descriptor memory: head and following entry read together
    dmaq_desc_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_desc_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (wr_ptr_reg),
        .wdata   (new_desc),
        .raddr_a (rd_ptr_reg),
        .raddr_b (rd_ptr_inc),
        .rdata_a (head_desc),
        .rdata_b (next_desc)
    );

    // sequencer and ring pointer control
    always_comb
    begin
        state_next           = state_reg;
        wr_ptr_next          = wr_ptr_reg;
        rd_ptr_next          = rd_ptr_reg;
        transfer_enable_next = transfer_enable_reg;
        strobe_next          = 1'b0;
        out_next             = out_reg;
        pend_next            = pend_reg;
        mem_we               = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_SUBMIT)
                    begin
                        strobe_next = 1'b1;
                        if (mode > MODE_MAX)
                        begin
                            out_next = status_res(STATUS_BAD_MODE);
                        end
                        else if (ring_full)
                        begin
                            out_next = status_res(STATUS_FULL);
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            wr_ptr_next = wr_ptr_inc;
                            if (ring_empty)
                            begin
                                transfer_enable_next = 1'b1;
                                out_next   = start_res(new_desc, chip_rev_reg, 1'b0);
                                pend_next  = status_res(STATUS_OK);
                                state_next = ST_SECOND;
                            end
                            else
                            begin
                                out_next = status_res(STATUS_OK);
                            end
                        end
                    end
                    else
                    begin
                        if (ring_empty)
                        begin
                            strobe_next = 1'b1;
                            out_next    = status_res(STATUS_SPURIOUS);
                        end
                        else
                        begin
                            // pop the head, descriptors arrive next cycle
                            rd_ptr_next          = rd_ptr_inc;
                            transfer_enable_next = 1'b0;
                            state_next           = ST_READ;
                        end
                    end
                end
            end

            ST_READ:
            begin
                state_next = ST_IDLE;
                if (!ring_empty)
                begin
                    transfer_enable_next = 1'b1;
                    strobe_next = 1'b1;
                    out_next    = start_res(next_desc, chip_rev_reg, !head_desc.notify);
                    if (head_desc.notify)
                    begin
                        pend_next  = done_res(head_desc.tag);
                        state_next = ST_SECOND;
                    end
                end
                else if (head_desc.notify)
                begin
                    strobe_next = 1'b1;
                    out_next    = done_res(head_desc.tag);
                end
            end

            ST_SECOND:
            begin
                strobe_next = 1'b1;
                out_next    = pend_reg;
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            wr_ptr_reg          <= '0;
            rd_ptr_reg          <= '0;
            transfer_enable_reg <= 1'b0;
            strobe_reg          <= 1'b0;
            chip_rev_reg        <= '0;
        end
        else
        begin
            state_reg           <= state_next;
            wr_ptr_reg          <= wr_ptr_next;
            rd_ptr_reg          <= rd_ptr_next;
            transfer_enable_reg <= transfer_enable_next;
            strobe_reg          <= strobe_next;
            if (cfg_valid && cfg_ready)
            begin
                chip_rev_reg <= cfg_data;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign result_strobe   = strobe_reg;
    assign kind            = out_reg.kind;
    assign status          = out_reg.status;
    assign dma_ctrl_value  = out_reg.ctrl;
    assign start_address   = out_reg.addr;
    assign start_count     = out_reg.count;
    assign start_direction = out_reg.dir;
    assign done_tag        = out_reg.tag;
    assign last            = out_reg.last;

    // in the idle state, the channel runs exactly while the ring holds a descriptor
    a_enable_matches_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (transfer_enable_reg == (wr_ptr_reg != rd_ptr_reg)))
        else $error("transfer enable out of step with ring occupancy");

    // a held second result always goes out next cycle
    a_second_emitted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SECOND) |=> (result_strobe && last))
        else $error("second result not delivered");

    // a submit into a full ring is refused
    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == ACT_SUBMIT) && (mode <= MODE_MAX) && ring_full)
        |=> (result_strobe && (status == STATUS_FULL) && $stable(wr_ptr_reg)))
        else $error("full ring accepted a descriptor");

    // pointers stay within the ring
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg <= PTR_LAST) && (rd_ptr_reg <= PTR_LAST))
        else $error("ring pointer out of range");

endmodule

// ===== design/dmaq_desc_ram.sv =====
module dmaq_desc_ram #(
    parameter int unsigned DEPTH  = 32,
    parameter int unsigned ADDR_W = 5
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  dmaq_pkg::desc_t       wdata,
    input  logic [ADDR_W-1:0]     raddr_a,
    input  logic [ADDR_W-1:0]     raddr_b,
    output dmaq_pkg::desc_t       rdata_a,
    output dmaq_pkg::desc_t       rdata_b
);
    import dmaq_pkg::*;

    desc_t desc_mem [DEPTH];
    desc_t rdata_a_reg;
    desc_t rdata_b_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            desc_mem[waddr] <= wdata;
        end
    end

    // two registered read ports
    always_ff @(posedge clk)
    begin
        rdata_a_reg <= desc_mem[raddr_a];
        rdata_b_reg <= desc_mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== tb/dma_descriptor_ring_queue_top_test.sv =====
module dma_descriptor_ring_queue_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import dmaq_pkg::*;

    localparam int unsigned RING_SLOTS   = QUEUE_DEPTH_DEF;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned SETTLE_TICKS = 8;
    localparam int unsigned PHASE_ITEMS  = 158;

    // ring state shadow and queue of expected results
    class ring_scoreboard;
        desc_t       ring [RING_SLOTS];
        int unsigned wr_ptr;
        int unsigned rd_ptr;
        logic [15:0] revision;
        res_t        pending_results [$];
        int          errors;

        function new();
            wr_ptr   = 0;
            rd_ptr   = 0;
            revision = '0;
            errors   = 0;
        endfunction

        function int unsigned ring_next(input int unsigned p);
            return (p + 1 >= RING_SLOTS) ? 0 : p + 1;
        endfunction

        function res_t status_report(input logic [1:0] st);
            res_t r;
            r        = '0;
            r.kind   = KIND_STATUS;
            r.status = st;
            r.last   = 1'b1;
            return r;
        endfunction

        // start command, control value taken from the current revision
        function res_t start_command(input desc_t d);
            res_t r;
            r       = '0;
            r.kind  = KIND_START;
            r.ctrl  = (revision < REV_NEW_MIN) ? CTRL_OLD : CTRL_NEW;
            if (d.mode == MODE_SPECIAL)
                r.ctrl[0] = 1'b1;
            r.addr  = d.addr;
            r.count = d.count;
            r.dir   = d.dir;
            return r;
        endfunction

        // work out the results of one accepted request
        function void note_request(input logic act, input logic [2:0] md,
                                   input logic [31:0] addr, input logic [31:0] count,
                                   input logic dir, input logic ntf, input logic [15:0] tg);
            desc_t d;
            desc_t head;
            res_t  r;
            int    n;
            bit    was_empty;
            n = 0;
            if (act == ACT_SUBMIT) begin
                if (md > MODE_MAX) begin
                    pending_results.push_back(status_report(STATUS_BAD_MODE));
                end
                else if (ring_next(wr_ptr) == rd_ptr) begin
                    pending_results.push_back(status_report(STATUS_FULL));
                end
                else begin
                    was_empty = (wr_ptr == rd_ptr);
                    d.mode    = md[1:0];
                    d.addr    = addr;
                    d.count   = count;
                    d.dir     = dir;
                    d.notify  = ntf;
                    d.tag     = tg;
                    ring[wr_ptr] = d;
                    wr_ptr = ring_next(wr_ptr);
                    if (was_empty)
                        pending_results.push_back(start_command(d));
                    pending_results.push_back(status_report(STATUS_OK));
                end
            end
            else begin
                if (wr_ptr == rd_ptr) begin
                    pending_results.push_back(status_report(STATUS_SPURIOUS));
                end
                else begin
                    head   = ring[rd_ptr];
                    rd_ptr = ring_next(rd_ptr);
                    if (wr_ptr != rd_ptr) begin
                        pending_results.push_back(start_command(ring[rd_ptr]));
                        n++;
                    end
                    if (head.notify) begin
                        r      = '0;
                        r.kind = KIND_DONE;
                        r.tag  = head.tag;
                        pending_results.push_back(r);
                        n++;
                    end
                    if (n > 0)
                        pending_results[pending_results.size() - 1].last = 1'b1;
                end
            end
        endfunction

        // compare one result with the oldest expectation
        function void check_result(input res_t got);
            res_t exp;
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d status %0d", got.kind, got.status);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.kind !== exp.kind) begin
                $error("kind: expected %0d, got %0d", exp.kind, got.kind);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.ctrl !== exp.ctrl) begin
                $error("dma_ctrl_value: expected %0d, got %0d", exp.ctrl, got.ctrl);
                errors++;
            end
            if (got.addr !== exp.addr) begin
                $error("start_address: expected %h, got %h", exp.addr, got.addr);
                errors++;
            end
            if (got.count !== exp.count) begin
                $error("start_count: expected %h, got %h", exp.count, got.count);
                errors++;
            end
            if (got.dir !== exp.dir) begin
                $error("start_direction: expected %0d, got %0d", exp.dir, got.dir);
                errors++;
            end
            if (got.tag !== exp.tag) begin
                $error("done_tag: expected %h, got %h", exp.tag, got.tag);
                errors++;
            end
            if (got.last !== exp.last) begin
                $error("last: expected %0d, got %0d", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        action;
    logic [2:0]  mode;
    logic [31:0] mem_address;
    logic [31:0] block_count;
    logic        direction;
    logic        notify;
    logic [15:0] tag;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        result_strobe;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [2:0]  dma_ctrl_value;
    logic [31:0] start_address;
    logic [31:0] start_count;
    logic        start_direction;
    logic [15:0] done_tag;
    logic        last;

    ring_scoreboard sb = new();
    int unsigned    idle_cycles = 0;

    dma_descriptor_ring_queue_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .mode            (mode),
        .mem_address     (mem_address),
        .block_count     (block_count),
        .direction       (direction),
        .notify          (notify),
        .tag             (tag),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .result_strobe   (result_strobe),
        .kind            (kind),
        .status          (status),
        .dma_ctrl_value  (dma_ctrl_value),
        .start_address   (start_address),
        .start_count     (start_count),
        .start_direction (start_direction),
        .done_tag        (done_tag),
        .last            (last)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_strobe === 1'b1)
            sb.check_result({kind, status, dma_ctrl_value, start_address, start_count,
                             start_direction, done_tag, last});
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n === 1'b1) begin
            if ((start && busy === 1'b0) || result_strobe === 1'b1 ||
                (cfg_valid && cfg_ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // present one request and hold it until taken
    task automatic send_request(input logic act, input logic [2:0] md,
                                input logic [31:0] addr, input logic [31:0] count,
                                input logic dir, input logic ntf, input logic [15:0] tg);
        start       <= 1'b1;
        action      <= act;
        mode        <= md;
        mem_address <= addr;
        block_count <= count;
        direction   <= dir;
        notify      <= ntf;
        tag         <= tg;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_request(act, md, addr, count, dir, ntf, tg);
        @(negedge clk);
    endtask

    // random gap between requests, mostly none or short
    task automatic request_gap(input bit enabled);
        int n;
        n = 0;
        if (enabled) begin
            if ($urandom_range(0, 19) == 0)
                n = $urandom_range(10, 40);
            else if ($urandom_range(0, 9) < 4)
                n = $urandom_range(1, 3);
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // hold off until every expected result is in, then let the block settle
    task automatic wait_idle();
        start <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_revision(input logic [15:0] rev);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= rev;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.revision = rev;
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= $urandom_range(0, 65535);
        @(negedge clk);
    endtask

    // random request, mostly valid modes
    task automatic random_request(input int submit_pct);
        logic       act;
        logic [2:0] md;
        act = ($urandom_range(0, 99) < submit_pct) ? ACT_SUBMIT : ACT_COMPLETE;
        md  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
        send_request(act, md, $urandom, $urandom, 1'($urandom), 1'($urandom),
                     16'($urandom));
    endtask

    initial
    begin
        logic [15:0] revs [6];
        int          pcts [3];
        int          p;
        int          i;
        bit          gaps_on;

        rst_n       = 1'b0;
        start       = 1'b0;
        action      = ACT_SUBMIT;
        mode        = '0;
        mem_address = '0;
        block_count = '0;
        direction   = 1'b0;
        notify      = 1'b0;
        tag         = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, old control encoding just below the threshold
        write_revision(16'd16);
        // completion on an empty ring
        send_request(ACT_COMPLETE, 3'd0, '0, '0, 1'b0, 1'b0, '0);
        // rejected modes
        for (i = 4; i < 8; i++)
            send_request(ACT_SUBMIT, 3'(i), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF);
        // first submit into an empty ring starts at once
        send_request(ACT_SUBMIT, 3'd0, 32'h0, 32'h0, 1'b0, 1'b1, 16'h0000);
        send_request(ACT_SUBMIT, 3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF);
        send_request(ACT_SUBMIT, 3'd2, 32'h5555_AAAA, 32'hAAAA_5555, 1'b0, 1'b0, 16'h1234);
        send_request(ACT_SUBMIT, 3'd3, 32'h1234_5678, 32'h8765_4321, 1'b1, 1'b1, 16'h5A5A);
        // bad mode while the ring holds entries
        send_request(ACT_SUBMIT, 3'd7, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0);
        // completions: start and done twice, start only, done only, then spurious
        for (i = 0; i < 5; i++)
            send_request(ACT_COMPLETE, 3'd0, '0, '0, 1'b0, 1'b0, '0);
        // completion that gives no result at all
        send_request(ACT_SUBMIT, 3'd1, 32'hDEAD_BEEF, 32'h0000_0010, 1'b1, 1'b0, 16'h0F0F);
        send_request(ACT_COMPLETE, 3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF);

        // random phases over several revisions, the extremes among them
        revs[0] = 16'd17;
        revs[1] = 16'd0;
        revs[2] = 16'hFFFF;
        revs[3] = 16'd16;
        revs[4] = 16'($urandom_range(0, 65535));
        revs[5] = 16'($urandom_range(17, 65535));
        pcts[0] = 85;
        pcts[1] = 55;
        pcts[2] = 25;
        for (p = 0; p < 6; p++) begin
            write_revision(revs[p]);
            gaps_on = (p % 3) != 1;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                // fill phases go through the full ring, drain phases through spurious
                random_request(pcts[(p + i / 60) % 3]);
                request_gap(gaps_on);
                if ($urandom_range(0, 49) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
